[design/dtsv_pkg.sv]
// ----------------------------------------------------------------------------
// dtsv_pkg
// Shared types, character codes and helpers for the date-time string checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsv_pkg;

	// string layout
	localparam logic [4:0] POS_DASH1  = 5'd4;
	localparam logic [4:0] POS_DASH2  = 5'd7;
	localparam logic [4:0] POS_NL     = 5'd10;
	localparam logic [4:0] POS_COLON1 = 5'd13;
	localparam logic [4:0] POS_COLON2 = 5'd16;
	localparam logic [4:0] DT_LEN     = 5'd19;
	localparam logic [4:0] POS_SAT    = 5'd20;

	// character codes
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// field limits
	localparam logic [6:0] MIN_MONTH   = 7'd1;
	localparam logic [6:0] MAX_MONTH   = 7'd12;
	localparam logic [6:0] MIN_DAY     = 7'd1;
	localparam logic [6:0] MAX_HOUR    = 7'd23;
	localparam logic [6:0] MAX_MIN_SEC = 7'd59;
	localparam logic [3:0] FEB         = 4'd2;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} req_t;

	typedef struct packed {
		logic        valid_res;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} res_t;

	// parser state after the current character
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  century;   // first two year digits
		logic [6:0]  year_lo;   // last two year digits
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        fmt_err;
		logic        len_ok;
	} acc_t;

	function automatic logic [6:0] dec7(input logic [6:0] a, input logic [3:0] d);
		logic [10:0] t;
		t = 11'({a, 3'b000}) + 11'({a, 1'b0}) + 11'(d);
		return t[6:0];
	endfunction

	function automatic logic [13:0] dec14(input logic [13:0] a, input logic [3:0] d);
		logic [17:0] t;
		t = 18'({a, 3'b000}) + 18'({a, 1'b0}) + 18'(d);
		return t[13:0];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (m == FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

[design/dtsv_parse.sv]
// ----------------------------------------------------------------------------
// dtsv_parse
// Position counter, separator/digit check and decimal accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsv_parse (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire dtsv_pkg::req_t item,
	output dtsv_pkg::acc_t      nxt
);

	logic [4:0]     pos_q;
	dtsv_pkg::acc_t acc_q;
	logic [4:0]     pos_d;
	logic           is_digit;
	logic [3:0]     dgt;
	logic [7:0]     ch;

	always_comb begin
		ch       = item.character;
		is_digit = ch inside {[dtsv_pkg::CH_ZERO:dtsv_pkg::CH_NINE]};
		dgt      = ch[3:0];
		nxt      = acc_q;
		if (pos_q >= dtsv_pkg::DT_LEN) begin
			nxt.fmt_err = 1'b1;
		end else if (pos_q == dtsv_pkg::POS_DASH1 || pos_q == dtsv_pkg::POS_DASH2) begin
			if (ch != dtsv_pkg::CH_DASH) nxt.fmt_err = 1'b1;
		end else if (pos_q == dtsv_pkg::POS_NL) begin
			if (ch != dtsv_pkg::CH_NL) nxt.fmt_err = 1'b1;
		end else if (pos_q == dtsv_pkg::POS_COLON1 || pos_q == dtsv_pkg::POS_COLON2) begin
			if (ch != dtsv_pkg::CH_COLON) nxt.fmt_err = 1'b1;
		end else if (!is_digit) begin
			nxt.fmt_err = 1'b1;
		end else if (pos_q < dtsv_pkg::POS_DASH1) begin
			nxt.year = dtsv_pkg::dec14(acc_q.year, dgt);
			if (pos_q < 5'd2) begin
				nxt.century = dtsv_pkg::dec7(acc_q.century, dgt);
			end else begin
				nxt.year_lo = dtsv_pkg::dec7(acc_q.year_lo, dgt);
			end
		end else if (pos_q < dtsv_pkg::POS_DASH2) begin
			nxt.month = dtsv_pkg::dec7(acc_q.month, dgt);
		end else if (pos_q < dtsv_pkg::POS_NL) begin
			nxt.day = dtsv_pkg::dec7(acc_q.day, dgt);
		end else if (pos_q < dtsv_pkg::POS_COLON1) begin
			nxt.hour = dtsv_pkg::dec7(acc_q.hour, dgt);
		end else if (pos_q < dtsv_pkg::POS_COLON2) begin
			nxt.minute = dtsv_pkg::dec7(acc_q.minute, dgt);
		end else begin
			nxt.second = dtsv_pkg::dec7(acc_q.second, dgt);
		end
		pos_d      = (pos_q < dtsv_pkg::POS_SAT) ? pos_q + 5'd1 : dtsv_pkg::POS_SAT;
		nxt.len_ok = (pos_d == dtsv_pkg::DT_LEN);
	end

	// state clears after the final character of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
		end else if (step) begin
			if (item.last_char) begin
				pos_q <= '0;
				acc_q <= '0;
			end else begin
				pos_q <= pos_d;
				acc_q <= nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= dtsv_pkg::POS_SAT)
		else $error("position above saturation");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_char |=> pos_q == 5'd0 && !acc_q.fmt_err)
		else $error("state not cleared after final character");
	a_err_past_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_q >= dtsv_pkg::DT_LEN |-> nxt.fmt_err && !nxt.len_ok)
		else $error("overlong string not flagged");
`endif

endmodule

`default_nettype wire

[design/dtsv_check.sv]
// ----------------------------------------------------------------------------
// dtsv_check
// Range check of the decoded fields, Gregorian leap rule, result build.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsv_check (
	input  wire dtsv_pkg::acc_t acc,
	output dtsv_pkg::res_t      res
);

	logic       leap;
	logic [4:0] mlen;
	logic       mon_ok;
	logic       ok;

	always_comb begin
		// y%100 is year_lo; y%400==0 iff year_lo==0 and century%4==0
		leap   = (acc.year_lo == 7'd0) ? (acc.century[1:0] == 2'b00)
		                                 : (acc.year_lo[1:0] == 2'b00);
		mlen   = dtsv_pkg::month_len(acc.month[3:0], leap);
		mon_ok = (acc.month >= dtsv_pkg::MIN_MONTH) && (acc.month <= dtsv_pkg::MAX_MONTH);
		ok     = !acc.fmt_err && acc.len_ok && mon_ok
		       && (acc.day >= dtsv_pkg::MIN_DAY) && (acc.day <= {2'b00, mlen})
		       && (acc.hour <= dtsv_pkg::MAX_HOUR)
		       && (acc.minute <= dtsv_pkg::MAX_MIN_SEC)
		       && (acc.second <= dtsv_pkg::MAX_MIN_SEC);
		res = '0;
		if (ok) begin
			res.valid_res = 1'b1;
			res.year      = acc.year;
			res.month     = acc.month[3:0];
			res.day       = acc.day[4:0];
			res.hour      = acc.hour[4:0];
			res.minute    = acc.minute[5:0];
			res.second    = acc.second[5:0];
		end
	end

endmodule

`default_nettype wire

[design/datetime_string_validator_unit.sv]
// ----------------------------------------------------------------------------
// datetime_string_validator_unit
// Checks a YYYY-MM-DD\nhh:mm:ss string, one character per request.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------
//  char    | char_valid / char_stall / char   | character, last_char
//  res     | res_valid  / res_stall  / res    | valid_res and date/time
//
//  One character per cycle while the input is not stalled; a final character
//  passes from the input register into the result register once it advances.
//  Characters without the last flag never wait on the result side.
//  A final character waits in the input register only while the result
//  register is full and stalled.
//  Asynchronous reset clears all valid flags and parser state.
`default_nettype none

module datetime_string_validator_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           char_valid,
	output logic                char_stall,
	input  wire dtsv_pkg::req_t char,
	output logic                res_valid,
	input  wire logic           res_stall,
	output dtsv_pkg::res_t      res
);

	dtsv_pkg::req_t char_s1;
	logic           vld_s1;
	logic           adv;
	dtsv_pkg::acc_t acc_nxt;
	dtsv_pkg::res_t res_d;

	assign adv        = vld_s1 && (!char_s1.last_char || !res_valid || !res_stall);
	assign char_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!char_stall) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall) begin
			char_s1 <= char;
		end
	end

	dtsv_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (char_s1),
		.nxt    (acc_nxt)
	);

	dtsv_check u_check (
		.acc (acc_nxt),
		.res (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv && char_s1.last_char) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && char_s1.last_char) begin
			res <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> vld_s1 && char_s1.last_char && res_valid && res_stall)
		else $error("input stalled without a blocked result");
	a_last_yields_res: assert property (@(posedge clk) disable iff (!arst_n)
		adv && char_s1.last_char |=> res_valid)
		else $error("final character produced no result");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.valid_res |-> res.year == 14'd0 && res.month == 4'd0
		&& res.day == 5'd0 && res.hour == 5'd0 && res.minute == 6'd0
		&& res.second == 6'd0)
		else $error("invalid result carries nonzero fields");
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.valid_res |-> res.month >= 4'd1 && res.month <= 4'd12
		&& res.day >= 5'd1 && res.hour <= 5'd23 && res.minute <= 6'd59
		&& res.second <= 6'd59)
		else $error("valid result out of range");
`endif

endmodule

`default_nettype wire
